>>> rtl/mpfp_pkg.sv
// mpfp_pkg: shared constants, command and pen codes, controller/datapath structs
// for the monochrome page frame buffer plotter; no dependencies
package mpfp_pkg;

  // default screen geometry
  localparam int ScreenWidthDefault  = 128;
  localparam int ScreenHeightDefault = 64;

  // fixed field widths
  localparam int CmdW   = 3;
  localparam int PenW   = 2;
  localparam int CoordW = 8;
  localparam int DataW  = 8;
  localparam int RAddrW = 10;

  // command codes
  localparam logic [CmdW-1:0] CmdPlot      = 3'd0;
  localparam logic [CmdW-1:0] CmdFill      = 3'd1;
  localparam logic [CmdW-1:0] CmdBlitStart = 3'd2;
  localparam logic [CmdW-1:0] CmdBlitByte  = 3'd3;
  localparam logic [CmdW-1:0] CmdRead      = 3'd4;

  // pen codes
  localparam logic [PenW-1:0] PenClear  = 2'd0;
  localparam logic [PenW-1:0] PenWrite  = 2'd1;
  localparam logic [PenW-1:0] PenInvert = 2'd2;

  // byte constants
  localparam logic [DataW-1:0] ByteOnes = 8'hFF;
  localparam logic [DataW-1:0] ByteMsb  = 8'h80;

  // memory address / data source select
  localparam logic [1:0] SelPageA = 2'd0;
  localparam logic [1:0] SelPageB = 2'd1;
  localparam logic [1:0] SelSweep = 2'd2;
  localparam logic [1:0] SelRead  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       latch_item;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       clear_pass;
    logic       sweep_clear;
    logic       sweep_inc;
    logic       blit_start;
    logic       blit_advance;
    logic       out_load;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            has_a;
    logic            has_b;
    logic            blit_skip;
    logic            sweep_last;
    logic            out_free;
  } stat_t;

endpackage

>>> rtl/mpfp_if.sv
// mpfp_if: valid/ready channel interfaces for command beats and read result beats
// depends on mpfp_pkg for field widths
interface mpfp_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [mpfp_pkg::CmdW-1:0]     command;
  logic [mpfp_pkg::PenW-1:0]     pen;
  logic [mpfp_pkg::CoordW-1:0]   x_coord;
  logic [mpfp_pkg::CoordW-1:0]   y_coord;
  logic [mpfp_pkg::CoordW-1:0]   bitmap_columns;
  logic [mpfp_pkg::CoordW-1:0]   bitmap_rows;
  logic [mpfp_pkg::DataW-1:0]    bitmap_byte;
  logic [mpfp_pkg::RAddrW-1:0]   read_address;

  modport source (
    output valid, command, pen, x_coord, y_coord, bitmap_columns, bitmap_rows,
           bitmap_byte, read_address,
    input  ready
  );
  modport sink (
    input  valid, command, pen, x_coord, y_coord, bitmap_columns, bitmap_rows,
           bitmap_byte, read_address,
    output ready
  );
endinterface

interface mpfp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [mpfp_pkg::DataW-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

>>> rtl/mpfp_ram.sv
// mpfp_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module mpfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mpfp_dpath.sv
// mpfp_dpath: item registers, bitmap cursor, page masks, frame store and result register
// depends on mpfp_pkg and mpfp_ram
module mpfp_dpath #(
  parameter int SCREEN_WIDTH  = mpfp_pkg::ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = mpfp_pkg::ScreenHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpfp_pkg::ctrl_t               ctrl_i,
  output mpfp_pkg::stat_t               stat_o,
  input  logic [mpfp_pkg::CmdW-1:0]     command_i,
  input  logic [mpfp_pkg::PenW-1:0]     pen_i,
  input  logic [mpfp_pkg::CoordW-1:0]   x_coord_i,
  input  logic [mpfp_pkg::CoordW-1:0]   y_coord_i,
  input  logic [mpfp_pkg::CoordW-1:0]   bitmap_columns_i,
  input  logic [mpfp_pkg::CoordW-1:0]   bitmap_rows_i,
  input  logic [mpfp_pkg::DataW-1:0]    bitmap_byte_i,
  input  logic [mpfp_pkg::RAddrW-1:0]   read_address_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [mpfp_pkg::DataW-1:0]    read_data_o
);

  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int Depth = Pages * SCREEN_WIDTH;
  localparam int AW    = $clog2(Depth);

  // latched item
  logic [mpfp_pkg::CmdW-1:0]   cmd_q;
  logic [mpfp_pkg::PenW-1:0]   pen_q;
  logic [mpfp_pkg::CoordW-1:0] x_q, y_q, cols_q, rows_q;
  logic [mpfp_pkg::DataW-1:0]  data_q;
  logic [mpfp_pkg::RAddrW-1:0] raddr_q;

  // bitmap cursor
  logic [7:0] ox_q, oy_q, bcols_q, brows_q, cc_q, rc_q;

  // sweep counter and result register
  logic [AW-1:0]              sweep_q;
  logic                       out_valid_q;
  logic [mpfp_pkg::DataW-1:0] out_data_q;

  // derived signals
  logic [7:0]    bx, ys, rem;
  logic [3:0]    n_bits;
  logic          blit_skip, is_blit, on_x;
  logic [7:0]    col_x;
  logic [4:0]    page_a, page_b;
  logic [7:0]    mask_a, mask_b, val_a, val_b;
  logic [AW-1:0] addr_a, addr_b, addr_rd;
  logic          in_range;
  logic [7:0]    rc_sum;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [7:0]    wdata_a, wdata_b, wdata_fill;

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_item) begin
      cmd_q   <= command_i;
      pen_q   <= pen_i;
      x_q     <= x_coord_i;
      y_q     <= y_coord_i;
      cols_q  <= bitmap_columns_i;
      rows_q  <= bitmap_rows_i;
      data_q  <= bitmap_byte_i;
      raddr_q <= read_address_i;
    end
  end

  // bitmap cursor geometry
  assign is_blit   = (cmd_q == mpfp_pkg::CmdBlitByte);
  assign bx        = ox_q + cc_q;
  assign ys        = oy_q + rc_q;
  assign rem       = brows_q - rc_q;
  assign n_bits    = (rem > 8'd8) ? 4'd8 : rem[3:0];
  assign blit_skip = (brows_q == 8'd0) || (cc_q >= bcols_q);
  assign col_x     = is_blit ? bx : x_q;
  assign on_x      = ({1'b0, col_x} < 9'(SCREEN_WIDTH));
  assign page_a    = is_blit ? ys[7:3] : y_q[7:3];
  assign page_b    = page_a + 5'd1;

  // pixel masks for the two pages a byte can touch
  always_comb begin
    logic [7:0] yt;
    logic [3:0] pos;
    logic       on;
    yt     = '0;
    pos    = '0;
    on     = 1'b0;
    mask_a = '0;
    mask_b = '0;
    val_a  = '0;
    val_b  = '0;
    if (is_blit) begin
      if (!blit_skip) begin
        for (int t = 0; t < 8; t++) begin
          yt  = ys + 8'(t);
          pos = {1'b0, ys[2:0]} + 4'(t);
          on  = (4'(t) < n_bits) && ({1'b0, yt} < 9'(SCREEN_HEIGHT)) && on_x;
          if (on) begin
            if (!pos[3]) begin
              mask_a[pos[2:0]] = 1'b1;
              val_a[pos[2:0]]  = data_q[7-t];
            end else begin
              mask_b[pos[2:0]] = 1'b1;
              val_b[pos[2:0]]  = data_q[7-t];
            end
          end
        end
      end
    end else if (on_x && ({1'b0, y_q} < 9'(SCREEN_HEIGHT))) begin
      mask_a[y_q[2:0]] = 1'b1;
    end
  end

  // byte addresses
  assign addr_a   = AW'(32'(page_a) * SCREEN_WIDTH + 32'(col_x));
  assign addr_b   = AW'(32'(page_b) * SCREEN_WIDTH + 32'(col_x));
  assign addr_rd  = AW'(raddr_q);
  assign in_range = (32'(raddr_q) < Depth);

  // read-modify-write data
  always_comb begin
    if (is_blit) begin
      wdata_a = (ram_rdata & ~mask_a) | val_a;
    end else begin
      unique case (pen_q)
        mpfp_pkg::PenWrite:  wdata_a = ram_rdata | mask_a;
        mpfp_pkg::PenInvert: wdata_a = ram_rdata ^ mask_a;
        default:             wdata_a = ram_rdata & ~mask_a;
      endcase
    end
    wdata_b = (ram_rdata & ~mask_b) | val_b;
    if (ctrl_i.clear_pass) begin
      wdata_fill = '0;
    end else begin
      unique case (pen_q)
        mpfp_pkg::PenWrite: wdata_fill = mpfp_pkg::ByteOnes;
        mpfp_pkg::PenClear: wdata_fill = '0;
        default:            wdata_fill = ~ram_rdata;
      endcase
    end
  end

  // memory port steering
  always_comb begin
    unique case (ctrl_i.wr_sel)
      mpfp_pkg::SelPageA: begin
        ram_waddr = addr_a;
        ram_wdata = wdata_a;
      end
      mpfp_pkg::SelPageB: begin
        ram_waddr = addr_b;
        ram_wdata = wdata_b;
      end
      mpfp_pkg::SelSweep: begin
        ram_waddr = sweep_q;
        ram_wdata = wdata_fill;
      end
      default: begin
        ram_waddr = addr_rd;
        ram_wdata = '0;
      end
    endcase
    unique case (ctrl_i.rd_sel)
      mpfp_pkg::SelPageA: ram_raddr = addr_a;
      mpfp_pkg::SelPageB: ram_raddr = addr_b;
      mpfp_pkg::SelSweep: ram_raddr = sweep_q;
      default:            ram_raddr = addr_rd;
    endcase
  end

  assign ram_we = ctrl_i.wr_en;

  mpfp_ram #(
    .Width (mpfp_pkg::DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // bitmap cursor update
  assign rc_sum = rc_q + {4'b0, n_bits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q    <= '0;
      oy_q    <= '0;
      bcols_q <= '0;
      brows_q <= '0;
      cc_q    <= '0;
      rc_q    <= '0;
    end else if (ctrl_i.blit_start) begin
      ox_q    <= x_q;
      oy_q    <= y_q;
      bcols_q <= cols_q;
      brows_q <= rows_q;
      cc_q    <= '0;
      rc_q    <= '0;
    end else if (ctrl_i.blit_advance) begin
      if (rc_sum == brows_q) begin
        rc_q <= '0;
        cc_q <= cc_q + 8'd1;
      end else begin
        rc_q <= rc_sum;
      end
    end
  end

  // sweep address for clear pass and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctrl_i.sweep_clear) begin
      sweep_q <= '0;
    end else if (ctrl_i.sweep_inc) begin
      sweep_q <= sweep_q + AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_data_q <= in_range ? ram_rdata : '0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // status back to the controller
  assign stat_o.cmd        = cmd_q;
  assign stat_o.has_a      = |mask_a;
  assign stat_o.has_b      = |mask_b;
  assign stat_o.blit_skip  = blit_skip;
  assign stat_o.sweep_last = (sweep_q == AW'(Depth - 1));
  assign stat_o.out_free   = !out_valid_q || rsp_ready_i;

  // result register never overwritten while held
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register loaded while a beat is stalled");

  // row cursor stays inside the bitmap column
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q == 8'd0) || (rc_q < brows_q))
    else $error("bitmap row count past bitmap height");

endmodule

>>> rtl/mpfp_ctrl.sv
// mpfp_ctrl: command sequencer for clear pass, plot, fill sweep, bitmap and read
// depends on mpfp_pkg
module mpfp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpfp_pkg::stat_t stat_i,
  output mpfp_pkg::ctrl_t ctrl_o
);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StExec   = 3'd2;
  localparam logic [2:0] StWrA    = 3'd3;
  localparam logic [2:0] StWrB    = 3'd4;
  localparam logic [2:0] StRead   = 3'd5;
  localparam logic [2:0] StFillRd = 3'd6;
  localparam logic [2:0] StFillWr = 3'd7;

  logic [2:0] state_q, state_d;
  logic       is_blit;

  assign is_blit = (stat_i.cmd == mpfp_pkg::CmdBlitByte);

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        ctrl_o.wr_en      = 1'b1;
        ctrl_o.wr_sel     = mpfp_pkg::SelSweep;
        ctrl_o.clear_pass = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = StIdle;
        end else begin
          ctrl_o.sweep_inc = 1'b1;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch_item = 1'b1;
          state_d           = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        unique case (stat_i.cmd)
          mpfp_pkg::CmdPlot: begin
            if (stat_i.has_a) begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = mpfp_pkg::SelPageA;
              state_d       = StWrA;
            end
          end
          mpfp_pkg::CmdFill: begin
            ctrl_o.sweep_clear = 1'b1;
            state_d            = StFillRd;
          end
          mpfp_pkg::CmdBlitStart: begin
            ctrl_o.blit_start = 1'b1;
          end
          mpfp_pkg::CmdBlitByte: begin
            if (!stat_i.blit_skip) begin
              if (stat_i.has_a) begin
                ctrl_o.rd_en  = 1'b1;
                ctrl_o.rd_sel = mpfp_pkg::SelPageA;
                state_d       = StWrA;
              end else if (stat_i.has_b) begin
                ctrl_o.rd_en  = 1'b1;
                ctrl_o.rd_sel = mpfp_pkg::SelPageB;
                state_d       = StWrB;
              end else begin
                ctrl_o.blit_advance = 1'b1;
              end
            end
          end
          mpfp_pkg::CmdRead: begin
            ctrl_o.rd_en  = 1'b1;
            ctrl_o.rd_sel = mpfp_pkg::SelRead;
            state_d       = StRead;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StWrA: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = mpfp_pkg::SelPageA;
        if (stat_i.has_b) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = mpfp_pkg::SelPageB;
          state_d       = StWrB;
        end else begin
          ctrl_o.blit_advance = is_blit;
          state_d             = StIdle;
        end
      end
      StWrB: begin
        ctrl_o.wr_en        = 1'b1;
        ctrl_o.wr_sel       = mpfp_pkg::SelPageB;
        ctrl_o.blit_advance = 1'b1;
        state_d             = StIdle;
      end
      StRead: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = StIdle;
        end
      end
      StFillRd: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = mpfp_pkg::SelSweep;
        state_d       = StFillWr;
      end
      default: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = mpfp_pkg::SelSweep;
        if (stat_i.sweep_last) begin
          state_d = StIdle;
        end else begin
          ctrl_o.sweep_inc = 1'b1;
          state_d          = StFillRd;
        end
      end
    endcase
  end

  // state register, reset starts the clear pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // an accepted beat is decoded in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted beat not decoded");

  // fill sweep ends after the last byte
  a_fill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFillWr && stat_i.sweep_last) |=> (state_q == StIdle))
    else $error("fill sweep did not terminate");

  // simultaneous read and write never target the same page slot
  a_port_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.rd_en && ctrl_o.wr_en) |-> (ctrl_o.rd_sel != ctrl_o.wr_sel))
    else $error("read and write share one address source");

endmodule

>>> rtl/mono_page_framebuffer_plotter_top.sv
// Usage: mono_page_framebuffer_plotter_top keeps a SCREEN_WIDTH x SCREEN_HEIGHT one-bit
// frame store as pages of column bytes (bit y%8 of byte [y/8][x] is pixel x,y).
// Command beats arrive on cmd_i (valid/ready); only the read command returns a beat,
// on rsp_o (valid/ready), carrying the addressed store byte or zero past the store.
// Path from one accepted beat to the next acceptance, set by the sequencer and the
// single write / single registered read port of the frame store:
//   bitmap start, unknown command: decode only
//   plot: decode with store read, then write (decode only when off screen)
//   bitmap byte: decode with store read, then a write per page touched (decode only
//   when ignored or when all of its pixels fall off screen)
//   read: decode with store read, then the result load once the register is free
//   fill: decode, then a read and a write of each byte of the sweep in turn
// A result beat that the receiver stalls sits in an output register while the next
// command beats are accepted; only a second read waits for the register to empty.
// After reset the store is swept to zero, one byte a cycle, all pages * SCREEN_WIDTH
// bytes of it (1024 at the default size), and cmd_i.ready stays low during that pass.
// The bitmap cursor and origin registers reset to zero.
// depends on mpfp_pkg, mpfp_if, mpfp_ctrl, mpfp_dpath
module mono_page_framebuffer_plotter_top #(
  parameter int SCREEN_WIDTH  = mpfp_pkg::ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = mpfp_pkg::ScreenHeightDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpfp_cmd_if.sink     cmd_i,
  mpfp_rsp_if.source   rsp_o
);

  mpfp_pkg::ctrl_t ctrl;
  mpfp_pkg::stat_t stat;

  // command sequencer
  mpfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // store, cursor and result datapath
  mpfp_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .command_i        (cmd_i.command),
    .pen_i            (cmd_i.pen),
    .x_coord_i        (cmd_i.x_coord),
    .y_coord_i        (cmd_i.y_coord),
    .bitmap_columns_i (cmd_i.bitmap_columns),
    .bitmap_rows_i    (cmd_i.bitmap_rows),
    .bitmap_byte_i    (cmd_i.bitmap_byte),
    .read_address_i   (cmd_i.read_address),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .read_data_o      (rsp_o.read_data)
  );

endmodule
